/* src/trac_pkg.sv */
// Shared types, constants and a helper function for the threshold relay alarm controller.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package trac_pkg;

  localparam int unsigned RELAY_W      = 5;
  localparam int unsigned RELAY_COUNT  = 5;
  localparam int unsigned RELAY_KEEP   = (RELAY_COUNT < RELAY_W) ? RELAY_COUNT : RELAY_W;
  localparam logic [RELAY_W-1:0] RELAY_MASK = RELAY_W'((64'd1 << RELAY_KEEP) - 64'd1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_CODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS      = 3'd6;

  // Mode codes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_BAND     = 3'd1;
  localparam logic [2:0] MODE_BAND_INV = 3'd2;
  localparam logic [2:0] MODE_HIGH_ON  = 3'd3;
  localparam logic [2:0] MODE_LOW_OFF  = 3'd4;
  localparam logic [2:0] MODE_HIGH_OFF = 3'd5;
  localparam logic [2:0] MODE_LOW_ON   = 3'd6;

  // Alert repeat interval codes
  localparam logic [2:0] IVL_2_MIN  = 3'd2;
  localparam logic [2:0] IVL_10_MIN = 3'd3;
  localparam logic [2:0] IVL_15_MIN = 3'd4;
  localparam logic [2:0] IVL_30_MIN = 3'd5;
  localparam logic [2:0] IVL_60_MIN = 3'd6;

  localparam logic [31:0] MINUTE_MS = 32'd60000;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] high_limit;
    logic signed [31:0] low_limit;
    logic [RELAY_W-1:0] controlled;
    logic [RELAY_W-1:0] auto_mask;
    logic [2:0]         interval_code;
    logic [1:0]         channels;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relays_driven;
    logic [RELAY_W-1:0] relay_state;
    logic               alert_channel_one;
    logic               alert_channel_two;
    logic               alert_level_high;
    logic               limit_crossed;
  } res_t;

  function automatic logic [31:0] interval_ms(input logic [2:0] code);
    logic [31:0] iv;
    unique case (code)
      IVL_2_MIN:  iv = 32'd2  * MINUTE_MS;
      IVL_10_MIN: iv = 32'd10 * MINUTE_MS;
      IVL_15_MIN: iv = 32'd15 * MINUTE_MS;
      IVL_30_MIN: iv = 32'd30 * MINUTE_MS;
      IVL_60_MIN: iv = 32'd60 * MINUTE_MS;
      default:    iv = 32'd0;
    endcase
    return iv;
  endfunction

endpackage

/* src/trac_cfg_regs.sv */
// Configuration register file of the threshold relay alarm controller.
// Depends on trac_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module trac_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [trac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output trac_pkg::cfg_t                   cfg
);
  import trac_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:          cfg_nxt.mode          = cfg_wdata[2:0];
        CFG_HIGH_LIMIT:    cfg_nxt.high_limit    = $signed(cfg_wdata);
        CFG_LOW_LIMIT:     cfg_nxt.low_limit     = $signed(cfg_wdata);
        CFG_CONTROLLED:    cfg_nxt.controlled    = cfg_wdata[RELAY_W-1:0];
        CFG_AUTO:          cfg_nxt.auto_mask     = cfg_wdata[RELAY_W-1:0];
        CFG_INTERVAL_CODE: cfg_nxt.interval_code = cfg_wdata[2:0];
        CFG_CHANNELS:      cfg_nxt.channels      = cfg_wdata[1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/trac_in_reg.sv */
// Input register stage of the threshold relay alarm controller.
// Depends on trac_pkg for the in_item_t bundle.
`timescale 1ns / 1ps

module trac_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  trac_pkg::in_item_t in_item,
  input  logic               dn_ready,
  output logic               s1_valid,
  output trac_pkg::in_item_t s1_item
);
  import trac_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Free when empty or when the held request moves on this cycle
  assign in_ready  = !valid_r || dn_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* src/trac_eval.sv */
// Threshold rule evaluation, relay state and alert rate limiter.
// Depends on trac_pkg for mode codes, interval table and bundles.
`timescale 1ns / 1ps

module trac_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  trac_pkg::cfg_t     cfg,
  input  trac_pkg::in_item_t s1_item,
  input  logic               step,
  output trac_pkg::res_t     res
);
  import trac_pkg::*;

  logic [RELAY_W-1:0] relay_r, relay_nxt;
  logic               sent_r, sent_nxt;
  logic [31:0]        last_r, last_nxt;

  logic [RELAY_W-1:0] ctl;
  logic [RELAY_W-1:0] driven;
  logic               active, above, below;
  logic               rule_on, rule_off, fired, alert;
  logic [31:0]        elapsed, iv;

  always_comb begin
    ctl     = cfg.controlled & RELAY_MASK;
    active  = (cfg.mode != MODE_OFF) && (ctl != '0);
    above   = s1_item.sample_value > cfg.high_limit;
    below   = s1_item.sample_value < cfg.low_limit;
    rule_on  = 1'b0;
    rule_off = 1'b0;
    priority if ((cfg.mode == MODE_BAND || cfg.mode == MODE_HIGH_ON) && above) begin
      rule_on = 1'b1;
    end else if ((cfg.mode == MODE_BAND || cfg.mode == MODE_LOW_OFF) && below) begin
      rule_off = 1'b1;
    end else if ((cfg.mode == MODE_BAND_INV || cfg.mode == MODE_HIGH_OFF) && above) begin
      rule_off = 1'b1;
    end else if ((cfg.mode == MODE_BAND_INV || cfg.mode == MODE_LOW_ON) && below) begin
      rule_on = 1'b1;
    end else begin
      // No rule applies: hold both flags low
      rule_on = 1'b0;
    end
    fired   = active && (rule_on || rule_off);
    driven  = fired ? (ctl & cfg.auto_mask) : '0;
    elapsed = s1_item.now_ms - last_r;
    iv      = interval_ms(cfg.interval_code);
    alert   = fired && (!sent_r || ((iv != 32'd0) && (elapsed >= iv)));

    relay_nxt = rule_on ? (relay_r | driven) : (relay_r & ~driven);
    sent_nxt  = sent_r;
    last_nxt  = last_r;
    if (active && !fired) begin
      // Back inside the band: re-arm
      sent_nxt = 1'b0;
      last_nxt = s1_item.now_ms;
    end else if (alert) begin
      sent_nxt = 1'b1;
      last_nxt = s1_item.now_ms;
    end

    res.relays_driven     = driven;
    res.relay_state       = relay_nxt;
    res.alert_channel_one = alert && cfg.channels[0];
    res.alert_channel_two = alert && cfg.channels[1];
    res.alert_level_high  = fired && above;
    res.limit_crossed     = fired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= '0;
      sent_r  <= 1'b0;
      last_r  <= '0;
    end else if (step) begin
      relay_r <= relay_nxt;
      sent_r  <= sent_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

/* src/trac_out_reg.sv */
// Result register stage of the threshold relay alarm controller.
// Depends on trac_pkg for the res_t bundle.
`timescale 1ns / 1ps

module trac_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  trac_pkg::res_t res_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output trac_pkg::res_t res_out
);
  import trac_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

/* src/threshold_relay_alarm_controller_top.sv */
// Top level of the threshold relay alarm controller.
// Depends on trac_pkg, trac_cfg_regs, trac_in_reg, trac_eval and trac_out_reg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one request carries a signed sample in
//   milli-units and a millisecond timestamp that wraps modulo 2^32.
//   Result channel (out_valid/out_ready): exactly one result per request, in
//   order: relays driven, relay on states, alert flags per channel, level and
//   whether a mode rule fired.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge; write only while no request is in flight.
// Pipeline and throughput
//   A request is held in the input register, evaluated in one pass against
//   the relay/alert state and captured in the result register, whose valid
//   flag drives out_valid. One request per cycle is sustained while
//   out_ready is high; the relay and alert state updates in the same cycle
//   a request moves into the result register, so the next request sees it
//   without a bubble.
// Reset (rst_n low, synchronous)
//   Clear both stages, all relays off, alert re-armed, last alert time and
//   all configuration registers zero (mode off).
// Receiver stall
//   Hold the result while out_ready is low; an empty input register still
//   takes one more request, then in_ready drops until the result is taken.

module threshold_relay_alarm_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  in_sample_value,
  input  logic [31:0]                         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [trac_pkg::RELAY_W-1:0]        out_relays_driven,
  output logic [trac_pkg::RELAY_W-1:0]        out_relay_state,
  output logic                                out_alert_channel_one,
  output logic                                out_alert_channel_two,
  output logic                                out_alert_level_high,
  output logic                                out_limit_crossed,
  input  logic                                cfg_we,
  input  logic [trac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trac_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import trac_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     can_load;
  logic     move;
  res_t     eval_res;
  res_t     out_res;

  assign in_item.sample_value = in_sample_value;
  assign in_item.now_ms       = in_now_ms;

  // Advance the held request whenever the result register is free
  assign move = s1_valid && can_load;

  trac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trac_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .dn_ready (can_load),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  trac_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .s1_item (s1_item),
    .step    (move),
    .res     (eval_res)
  );

  trac_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move),
    .res_in    (eval_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  assign out_relays_driven     = out_res.relays_driven;
  assign out_relay_state       = out_res.relay_state;
  assign out_alert_channel_one = out_res.alert_channel_one;
  assign out_alert_channel_two = out_res.alert_channel_two;
  assign out_alert_level_high  = out_res.alert_level_high;
  assign out_limit_crossed     = out_res.limit_crossed;

endmodule

/* src/trac_checker.sv */
// Port-level checks for the threshold relay alarm controller, bound to the top level.
// Depends on trac_pkg for the relay mask width.
`timescale 1ns / 1ps

module trac_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [trac_pkg::RELAY_W-1:0] out_relays_driven,
  input logic [trac_pkg::RELAY_W-1:0] out_relay_state,
  input logic                         out_alert_channel_one,
  input logic                         out_alert_channel_two,
  input logic                         out_alert_level_high,
  input logic                         out_limit_crossed
);
  import trac_pkg::*;

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relays_driven)
      && $stable(out_relay_state) && $stable(out_limit_crossed))
    else $error("result changed while stalled");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Without a fired rule nothing is driven and no alert goes out
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_limit_crossed |-> out_relays_driven == '0
      && !out_alert_channel_one && !out_alert_channel_two && !out_alert_level_high)
    else $error("activity without a fired rule");

  // Driven relays all end up at one level
  a_driven_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_relay_state & out_relays_driven) == out_relays_driven)
      || ((out_relay_state & out_relays_driven) == '0))
    else $error("driven relays at mixed levels");

endmodule

bind threshold_relay_alarm_controller_top trac_checker u_trac_checker (.*);
